// ===== sv/acrp_pkg.sv =====
package acrp_pkg;

    localparam int SIDE        = 64;
    localparam int COORD_W     = $clog2(SIDE);
    localparam int INDEX_W     = 2 * COORD_W;
    localparam int DEPTH       = SIDE * SIDE;
    localparam int SIZE_W      = 7;
    localparam int PIXEL_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int S_DATA_W    = 48;
    localparam int S_USER_W    = 2;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_90   = 2'd1,
        ROT_180  = 2'd2,
        ROT_270  = 2'd3
    } rot_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FETCH = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load_en;
        logic read_en;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_valid;
    } ctrl_status_t;

endpackage

// ===== sv/acrp_ctrl.sv =====
module acrp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  opcode,
    input  logic                  m_tready,
    input  acrp_pkg::ctrl_status_t status,
    output logic                  s_tready,
    output acrp_pkg::ctrl_cmd_t   cmd
);
    import acrp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;
    logic        out_free;

    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !status.out_valid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && opcode == OP_READ) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.load_en  = 1'b0;
        cmd.read_en  = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_en = accept && opcode == OP_LOAD;
                cmd.read_en = accept && opcode == OP_READ;
            end
            ST_FETCH: begin
                cmd.out_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/acrp_datapath.sv =====
module acrp_datapath #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  acrp_pkg::ctrl_cmd_t                 cmd,
    output acrp_pkg::ctrl_status_t              status,
    input  logic                                cfg_wen,
    input  logic [acrp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [acrp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                first,
    input  logic [acrp_pkg::PIXEL_W-1:0]        pixel,
    input  logic [acrp_pkg::INDEX_W-1:0]        out_index,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [acrp_pkg::PIXEL_W-1:0]        out_pixel
);
    import acrp_pkg::*;

    rot_t                   rotation_reg;
    logic [SIZE_W-1:0]      image_width_reg;
    logic [SIZE_W-1:0]      image_height_reg;
    logic [SIZE_W-1:0]      w_eff;
    logic [SIZE_W-1:0]      h_eff;

    logic [SIZE_W-1:0]      load_row_reg;
    logic [SIZE_W-1:0]      load_row_next;
    logic [COORD_W-1:0]     load_col_reg;
    logic [COORD_W-1:0]     load_col_next;
    logic [SIZE_W-1:0]      row_base;
    logic [COORD_W-1:0]     col_base;
    logic [SIZE_W-1:0]      col_inc;
    logic                   load_in;
    logic [INDEX_W-1:0]     wr_addr;

    logic [COORD_W-1:0]     rd_row;
    logic [COORD_W-1:0]     rd_col;
    logic [COORD_W-1:0]     src_y;
    logic [COORD_W-1:0]     src_x;
    logic                   hit;
    logic [INDEX_W-1:0]     rd_addr;

    logic [PIXEL_BITS-1:0]  pixel_store [DEPTH];
    logic [PIXEL_BITS-1:0]  rd_data_reg;
    logic                   hit_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [PIXEL_W-1:0]     out_data_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg     <= ROT_NONE;
            image_width_reg  <= SIZE_W'(SIDE);
            image_height_reg <= SIZE_W'(SIDE);
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_ROTATION:     rotation_reg     <= rot_t'(cfg_wdata[1:0]);
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign w_eff = (image_width_reg > SIZE_W'(SIDE)) ? SIZE_W'(SIDE) : image_width_reg;
    assign h_eff = (image_height_reg > SIZE_W'(SIDE)) ? SIZE_W'(SIDE) : image_height_reg;

    // load position
    assign row_base = first ? '0 : load_row_reg;
    assign col_base = first ? '0 : load_col_reg;
    assign load_in  = (row_base < h_eff) && ({1'b0, col_base} < w_eff);
    assign col_inc  = {1'b0, col_base} + SIZE_W'(1);
    assign wr_addr  = {row_base[COORD_W-1:0], col_base};

    always_comb begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        if (cmd.load_en) begin
            load_row_next = row_base;
            load_col_next = col_base;
            if (load_in) begin
                if (col_inc >= w_eff) begin
                    load_col_next = '0;
                    load_row_next = row_base + SIZE_W'(1);
                end else begin
                    load_col_next = col_inc[COORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_row_reg <= '0;
            load_col_reg <= '0;
        end else begin
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
        end
    end

    // output point back to source point
    assign rd_row = out_index[INDEX_W-1:COORD_W];
    assign rd_col = out_index[COORD_W-1:0];

    always_comb begin
        case (rotation_reg)
            ROT_90: begin
                src_y = rd_col;
                src_x = COORD_W'(SIDE - 1) - rd_row;
            end
            ROT_180: begin
                src_y = COORD_W'(SIDE - 1) - rd_row;
                src_x = COORD_W'(SIDE - 1) - rd_col;
            end
            ROT_270: begin
                src_y = COORD_W'(SIDE - 1) - rd_col;
                src_x = rd_row;
            end
            default: begin
                src_y = rd_row;
                src_x = rd_col;
            end
        endcase
    end

    assign hit     = ({1'b0, src_y} < h_eff) && ({1'b0, src_x} < w_eff);
    assign rd_addr = {src_y, src_x};

    always_ff @(posedge aclk) begin
        if (cmd.load_en && load_in) begin
            pixel_store[wr_addr] <= pixel[PIXEL_BITS-1:0];
        end
        if (cmd.read_en) begin
            rd_data_reg <= pixel_store[rd_addr];
            hit_reg     <= hit;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= hit_reg ? PIXEL_W'(rd_data_reg) : '0;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign m_tvalid         = out_valid_reg;
    assign out_pixel        = out_data_reg;

endmodule

// ===== sv/argb_cursor_rotation_pad.sv =====
// channel   direction  payload
// s_        in         tdata: pixel, out_index; tuser: opcode, first
// m_        out        tdata: out_pixel
// cfg_      in         index 0 rotation, 1 image_width, 2 image_height
//
// a load leaves the block idle to take the next input; a read passes the registered
// read port of the pixel memory, then the output register, held while the output stalls
// loads are taken while a result waits in the output register
// aresetn clears the control state, load position and config registers;
// the pixel memory is not cleared and holds stale pixels across reloads
module argb_cursor_rotation_pad #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [acrp_pkg::S_DATA_W-1:0]       s_tdata,  // pixel, out_index, unused pad
    input  logic [acrp_pkg::S_USER_W-1:0]       s_tuser,  // opcode, first
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [acrp_pkg::PIXEL_W-1:0]        m_tdata,  // out_pixel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [acrp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [acrp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import acrp_pkg::*;

    ctrl_cmd_t          cmd;
    ctrl_status_t       status;
    logic               opcode;
    logic               first;
    logic [PIXEL_W-1:0] pixel;
    logic [INDEX_W-1:0] out_index;

    assign opcode    = s_tuser[0];
    assign first     = s_tuser[1];
    assign pixel     = s_tdata[PIXEL_W-1:0];
    assign out_index = s_tdata[PIXEL_W+INDEX_W-1:PIXEL_W];
    assign cfg_ready = 1'b1;

    acrp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .opcode   (opcode),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    acrp_datapath #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_wen   (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .first     (first),
        .pixel     (pixel),
        .out_index (out_index),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_pixel (m_tdata)
    );

    a_read_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && opcode == OP_READ) |=> !s_tready)
        else $error("input taken while a read is in flight");

    a_load_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && opcode == OP_LOAD) |=> s_tready)
        else $error("load did not return to idle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output word overwritten before taken");

    a_read_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && opcode == OP_READ && !m_tvalid) |=> ##1 m_tvalid)
        else $error("read produced no output word");

endmodule
